@@ sv/hrpc_pkg.sv @@
// Shared types, constants and helpers for the H.264 RTP parameter-set capture block.
`default_nettype none

package hrpc_pkg;

	// Store sizes, in bytes per bank
	localparam int SPS_CAPACITY = 256;
	localparam int PPS_CAPACITY = 256;
	localparam int CAP_MAX = (SPS_CAPACITY > PPS_CAPACITY) ? SPS_CAPACITY : PPS_CAPACITY;
	// Write count saturates one above the larger store
	localparam int CNT_MAX = CAP_MAX + 1;
	localparam int CNT_BITS = $clog2(CNT_MAX + 1);
	localparam int LEN_W = (CNT_BITS > 9) ? CNT_BITS : 9;
	// Two banks per store
	localparam int SPS_AW = $clog2(2 * SPS_CAPACITY);
	localparam int PPS_AW = $clog2(2 * PPS_CAPACITY);
	localparam int MEM_AW = (SPS_AW > PPS_AW) ? SPS_AW : PPS_AW;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	// NAL header decoding
	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;
	localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
	localparam logic [4:0] NAL_STAP_A = 5'd24;

	// Request, result and store codes
	localparam logic REQ_PAYLOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;
	localparam logic SEL_SPS = 1'b0;
	localparam logic SEL_PPS = 1'b1;
	localparam logic [0:0] REG_CAPTURE_ENABLE = 1'b0;

	typedef enum logic {
		RES_REPORT = 1'b0,
		RES_READ = 1'b1
	} res_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_IGNORE = 3'd1,
		PH_SINGLE = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_LEN_LO = 3'd4,
		PH_BODY = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_SPS = 2'd1,
		TGT_PPS = 2'd2,
		TGT_OTHER = 2'd3
	} tgt_t;

	// One queued command: an optional store write and an optional result
	typedef struct packed {
		logic we;
		logic wsel;
		logic [MEM_AW-1:0] waddr;
		logic [7:0] wdata;
		logic res;
		res_kind_t kind;
		logic rok;
		logic rsel;
		logic [MEM_AW-1:0] raddr;
		logic [8:0] sps_len;
		logic [8:0] pps_len;
		logic apply;
	} hrpc_cmd_t;

	// Map a NAL header byte to its store
	function automatic tgt_t target_of(input logic [7:0] b);
		logic [4:0] t;
		t = b[4:0] & NAL_TYPE_MASK;
		if (t == NAL_SPS) return TGT_SPS;
		if (t == NAL_PPS) return TGT_PPS;
		return TGT_OTHER;
	endfunction

endpackage

`default_nettype wire

@@ sv/hrpc_front.sv @@
// Front end: parses payload bytes, tracks banks and lengths, issues store and result commands.
`default_nettype none

module hrpc_front import hrpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic capture_enable,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic req_type,
	input wire logic [7:0] data_byte,
	input wire logic first_byte,
	input wire logic last_byte,
	input wire logic source_ready,
	input wire logic read_select,
	input wire logic [7:0] read_index,
	output logic push,
	output hrpc_cmd_t cmd
);

	phase_t ph_q, ph_n;
	logic [15:0] rem_q, rem_n;
	logic [LEN_W-1:0] cnt_q, cnt_n;
	tgt_t tgt_q, tgt_n;
	logic [1:0] pbc_q, pbc_n;
	logic sps_bank_q, sps_bank_n, pps_bank_q, pps_bank_n;
	logic [LEN_W-1:0] sps_len_q, sps_len_n, pps_len_q, pps_len_n;

	logic st_do;
	tgt_t st_tgt;
	logic [LEN_W-1:0] st_idx;
	logic cm_do;
	tgt_t cm_tgt;
	logic [LEN_W-1:0] cm_n;
	logic rep_do;
	logic apply_v;
	logic accept;

	assign accept = in_valid && in_ready;

	// Next state, store and commit decisions
	always_comb begin
		logic [4:0] t;
		logic [15:0] rem_lo;
		tgt_t t2;
		t = data_byte[4:0] & NAL_TYPE_MASK;
		rem_lo = '0;
		t2 = TGT_NONE;
		ph_n = ph_q;
		rem_n = rem_q;
		cnt_n = cnt_q;
		tgt_n = tgt_q;
		pbc_n = pbc_q;
		sps_bank_n = sps_bank_q;
		pps_bank_n = pps_bank_q;
		sps_len_n = sps_len_q;
		pps_len_n = pps_len_q;
		st_do = 1'b0;
		st_tgt = TGT_NONE;
		st_idx = '0;
		cm_do = 1'b0;
		cm_tgt = TGT_NONE;
		cm_n = '0;
		rep_do = 1'b0;
		apply_v = 1'b0;
		if (req_type == REQ_PAYLOAD) begin
			if (first_byte) begin
				// Open a new payload, dropping any NAL in progress
				pbc_n = 2'd1;
				cnt_n = '0;
				rem_n = '0;
				tgt_n = TGT_NONE;
				if (!capture_enable || source_ready) begin
					ph_n = PH_IGNORE;
				end else if (t >= 5'd1 && t <= NAL_SINGLE_MAX) begin
					ph_n = PH_SINGLE;
					tgt_n = target_of(data_byte);
					st_do = 1'b1;
					st_tgt = tgt_n;
					st_idx = '0;
					cnt_n = LEN_W'(1);
				end else if (t == NAL_STAP_A) begin
					ph_n = PH_LEN_HI;
				end else begin
					ph_n = PH_IGNORE;
				end
			end else if (ph_q != PH_IDLE) begin
				if (pbc_q < 2'd2) pbc_n = pbc_q + 2'd1;
				unique case (ph_q)
					PH_SINGLE: begin
						st_do = 1'b1;
						st_tgt = tgt_q;
						st_idx = cnt_q;
						if (cnt_q < LEN_W'(CNT_MAX)) cnt_n = cnt_q + LEN_W'(1);
						if (last_byte) begin
							cm_do = 1'b1;
							cm_tgt = tgt_q;
							cm_n = cnt_n;
						end
					end
					PH_LEN_HI: begin
						rem_n = {data_byte, 8'h00};
						ph_n = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						rem_lo = rem_q | {8'h00, data_byte};
						rem_n = rem_lo;
						if (rem_lo == 16'd0) begin
							ph_n = PH_IGNORE;
						end else begin
							cnt_n = '0;
							tgt_n = TGT_NONE;
							ph_n = PH_BODY;
						end
					end
					PH_BODY: begin
						t2 = (cnt_q == '0) ? target_of(data_byte) : tgt_q;
						st_do = 1'b1;
						st_tgt = t2;
						st_idx = cnt_q;
						if (cnt_q < LEN_W'(CNT_MAX)) cnt_n = cnt_q + LEN_W'(1);
						rem_n = rem_q - 16'd1;
						tgt_n = t2;
						if (rem_n == 16'd0) begin
							cm_do = 1'b1;
							cm_tgt = t2;
							cm_n = cnt_n;
							cnt_n = '0;
							tgt_n = TGT_NONE;
							ph_n = PH_LEN_HI;
						end
					end
					default: begin
					end
				endcase
			end
			// Flip the bank once a complete NAL fits its store
			if (cm_do && cm_n != '0) begin
				if (cm_tgt == TGT_SPS && cm_n <= LEN_W'(SPS_CAPACITY)) begin
					sps_bank_n = !sps_bank_q;
					sps_len_n = cm_n;
				end else if (cm_tgt == TGT_PPS && cm_n <= LEN_W'(PPS_CAPACITY)) begin
					pps_bank_n = !pps_bank_q;
					pps_len_n = cm_n;
				end
			end
			// Close the payload and report
			if (last_byte) begin
				rep_do = 1'b1;
				apply_v = capture_enable && !source_ready && (pbc_n >= 2'd2) &&
					(sps_len_n != '0) && (pps_len_n != '0);
				ph_n = PH_IDLE;
				pbc_n = '0;
				rem_n = '0;
				cnt_n = '0;
				tgt_n = TGT_NONE;
			end
		end
	end

	// Build the queued command
	always_comb begin
		cmd = '0;
		cmd.kind = RES_REPORT;
		cmd.wdata = data_byte;
		cmd.sps_len = sps_len_n[8:0];
		cmd.pps_len = pps_len_n[8:0];
		if (req_type == REQ_READ) begin
			cmd.res = 1'b1;
			cmd.kind = RES_READ;
			cmd.rsel = read_select;
			cmd.sps_len = sps_len_q[8:0];
			cmd.pps_len = pps_len_q[8:0];
			if (read_select == SEL_SPS) begin
				cmd.rok = (LEN_W'(read_index) < sps_len_q) && (32'(read_index) < SPS_CAPACITY);
				cmd.raddr = MEM_AW'(sps_bank_q ? (SPS_CAPACITY + 32'(read_index))
					: 32'(read_index));
			end else begin
				cmd.rok = (LEN_W'(read_index) < pps_len_q) && (32'(read_index) < PPS_CAPACITY);
				cmd.raddr = MEM_AW'(pps_bank_q ? (PPS_CAPACITY + 32'(read_index))
					: 32'(read_index));
			end
		end else begin
			// Store into the idle bank
			if (st_do && st_tgt == TGT_SPS && 32'(st_idx) < SPS_CAPACITY) begin
				cmd.we = 1'b1;
				cmd.wsel = SEL_SPS;
				cmd.waddr = MEM_AW'(!sps_bank_q ? (SPS_CAPACITY + 32'(st_idx)) : 32'(st_idx));
			end else if (st_do && st_tgt == TGT_PPS && 32'(st_idx) < PPS_CAPACITY) begin
				cmd.we = 1'b1;
				cmd.wsel = SEL_PPS;
				cmd.waddr = MEM_AW'(!pps_bank_q ? (PPS_CAPACITY + 32'(st_idx)) : 32'(st_idx));
			end
			cmd.res = rep_do;
			cmd.apply = apply_v;
		end
	end

	assign push = accept && (cmd.we || cmd.res);

	// Advance parse state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			rem_q <= '0;
			cnt_q <= '0;
			tgt_q <= TGT_NONE;
			pbc_q <= '0;
			sps_bank_q <= 1'b0;
			pps_bank_q <= 1'b0;
			sps_len_q <= '0;
			pps_len_q <= '0;
		end else if (accept) begin
			ph_q <= ph_n;
			rem_q <= rem_n;
			cnt_q <= cnt_n;
			tgt_q <= tgt_n;
			pbc_q <= pbc_n;
			sps_bank_q <= sps_bank_n;
			pps_bank_q <= pps_bank_n;
			sps_len_q <= sps_len_n;
			pps_len_q <= pps_len_n;
		end
	end

endmodule

`default_nettype wire

@@ sv/hrpc_queue.sv @@
// Short command queue that decouples the parser from the store and output side.
`default_nettype none

module hrpc_queue import hrpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire hrpc_cmd_t push_cmd,
	output logic not_full,
	input wire logic pop,
	output logic not_empty,
	output hrpc_cmd_t head
);

	hrpc_cmd_t ent_q [QDEPTH];
	logic [QPW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	assign not_full = (cnt_q != QCW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = ent_q[rd_q];

	// Hold entries; payload needs no reset
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + QPW'(1);
			if (pop) rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + QPW'(1);
			if (push && !pop) cnt_q <= cnt_q + QCW'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + QCW'(1)))
		else $error("queue count did not advance");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ sv/hrpc_back.sv @@
// Back end: double-banked parameter-set stores and the registered result stage.
`default_nettype none

module hrpc_back import hrpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_not_empty,
	input wire hrpc_cmd_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output res_kind_t result_kind,
	output logic [8:0] sps_length,
	output logic [8:0] pps_length,
	output logic apply_sets,
	output logic [7:0] read_data
);

	logic [7:0] sps_mem [2*SPS_CAPACITY];
	logic [7:0] pps_mem [2*PPS_CAPACITY];

	logic valid_s1;
	res_kind_t kind_s1;
	logic [8:0] sps_len_s1, pps_len_s1;
	logic apply_s1, rok_s1, rsel_s1;
	logic [7:0] sps_rd_s1, pps_rd_s1;
	logic rd_sps, rd_pps;

	// Commands without a result drain freely; a result needs the output stage free
	assign pop = q_not_empty && (!head.res || !valid_s1 || out_ready);
	assign rd_sps = pop && head.res && head.rok && (head.rsel == SEL_SPS);
	assign rd_pps = pop && head.res && head.rok && (head.rsel == SEL_PPS);

	// SPS store
	always_ff @(posedge clk) begin
		if (pop && head.we && head.wsel == SEL_SPS) sps_mem[head.waddr[SPS_AW-1:0]] <= head.wdata;
		if (rd_sps) sps_rd_s1 <= sps_mem[head.raddr[SPS_AW-1:0]];
	end

	// PPS store
	always_ff @(posedge clk) begin
		if (pop && head.we && head.wsel == SEL_PPS) pps_mem[head.waddr[PPS_AW-1:0]] <= head.wdata;
		if (rd_pps) pps_rd_s1 <= pps_mem[head.raddr[PPS_AW-1:0]];
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop && head.res) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (pop && head.res) begin
			kind_s1 <= head.kind;
			sps_len_s1 <= head.sps_len;
			pps_len_s1 <= head.pps_len;
			apply_s1 <= head.apply;
			rok_s1 <= head.rok;
			rsel_s1 <= head.rsel;
		end
	end

	assign out_valid = valid_s1;
	assign result_kind = kind_s1;
	assign sps_length = sps_len_s1;
	assign pps_length = pps_len_s1;
	assign apply_sets = apply_s1;
	assign read_data = !rok_s1 ? 8'h00 : ((rsel_s1 == SEL_PPS) ? pps_rd_s1 : sps_rd_s1);

	a_stall_blocks_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready && head.res) |-> !pop)
		else $error("result popped into a stalled stage");
	a_report_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == RES_REPORT) |-> (read_data == 8'h00))
		else $error("report carries read data");
	a_read_no_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == RES_READ) |-> !apply_sets)
		else $error("read result with apply set");

endmodule

`default_nettype wire

@@ sv/h264_rtp_param_set_capture_top.sv @@
// Top level: stream ports, configuration register, front parser, queue and store back end.
// A result beat passes through the command queue and the registered result stage before it is offered.
// Throughput: one input beat per cycle while the command queue is not full; the four-entry
// queue absorbs output stalls, and one store access per cycle in the back end sets that rate.
// Reset (arst_n low) clears parse state, bank selects, lengths, queue and output valid.
// Store contents are not cleared; only bytes within a committed length are ever read.
`default_nettype none

module h264_rtp_param_set_capture_top import hrpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	// APB configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// Input stream
	input wire logic s_tvalid,
	output logic s_tready,
	// [7:0] data_byte, [8] first_byte, [9] source_ready, [17:10] read_index, [23:18] zero
	input wire logic [23:0] s_tdata,
	// [0] req_type, [1] read_select
	input wire logic [1:0] s_tuser,
	input wire logic s_tlast,
	// Output stream
	output logic m_tvalid,
	input wire logic m_tready,
	// [8:0] sps_length, [17:9] pps_length, [18] apply_sets, [26:19] read_data, [31:27] zero
	output logic [31:0] m_tdata,
	// [0] result_kind
	output logic m_tuser
);

	logic capture_enable_q;
	logic push, q_not_full, q_not_empty, pop;
	hrpc_cmd_t push_cmd, head;
	res_kind_t result_kind;
	logic [8:0] sps_length, pps_length;
	logic apply_sets;
	logic [7:0] read_data;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_CAPTURE_ENABLE) begin
			capture_enable_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2:2] == REG_CAPTURE_ENABLE) ? {31'd0, capture_enable_q} : 32'd0;

	assign s_tready = q_not_full;

	hrpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.capture_enable(capture_enable_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.req_type(s_tuser[0]),
		.data_byte(s_tdata[7:0]),
		.first_byte(s_tdata[8]),
		.last_byte(s_tlast),
		.source_ready(s_tdata[9]),
		.read_select(s_tuser[1]),
		.read_index(s_tdata[17:10]),
		.push(push),
		.cmd(push_cmd)
	);

	hrpc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.not_full(q_not_full),
		.pop(pop),
		.not_empty(q_not_empty),
		.head(head)
	);

	hrpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.head(head),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.result_kind(result_kind),
		.sps_length(sps_length),
		.pps_length(pps_length),
		.apply_sets(apply_sets),
		.read_data(read_data)
	);

	assign m_tdata = {5'd0, read_data, apply_sets, pps_length, sps_length};
	assign m_tuser = result_kind;

endmodule

`default_nettype wire

@@ verif/h264_rtp_param_set_capture_checker.sv @@
// Scoreboard for the parameter-set capture block: predicts every result beat and compares.
`timescale 1ns / 1ps

module h264_rtp_param_set_capture_checker import hrpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [23:0] s_tdata,
	input wire logic [1:0] s_tuser,
	input wire logic s_tlast,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic m_tuser,
	output int fail_count,
	output int pending,
	output int reports_seen,
	output int reads_seen,
	output int sets_committed
);

	localparam logic [2:0] CAPTURE_ENABLE_ADDR = {REG_CAPTURE_ENABLE, 2'b00};

	typedef struct packed {
		res_kind_t kind;
		logic [8:0] sps_len;
		logic [8:0] pps_len;
		logic apply;
		logic [7:0] rdata;
	} capture_result_t;

	capture_result_t expected_q[$];
	int mismatches;

	// Shadow of the block state
	logic cap_en;
	phase_t phase;
	logic [15:0] nal_left;
	logic [15:0] nal_count;
	tgt_t nal_dest;
	logic [1:0] payload_seen;
	logic [7:0] sps_store [0:2*SPS_CAPACITY-1];
	logic [7:0] pps_store [0:2*PPS_CAPACITY-1];
	// Bank that holds the committed set; writes go to the other one
	logic sps_bank;
	logic pps_bank;
	logic [15:0] sps_len;
	logic [15:0] pps_len;

	function automatic tgt_t dest_of(input logic [7:0] b);
		case (b[4:0])
			NAL_SPS: return TGT_SPS;
			NAL_PPS: return TGT_PPS;
			default: return TGT_OTHER;
		endcase
	endfunction

	// Write one NAL byte into the idle bank of its store, if it fits
	task automatic store_nal_byte(input logic [7:0] b);
		if (nal_dest == TGT_SPS && nal_count < SPS_CAPACITY) begin
			sps_store[(sps_bank ? 0 : SPS_CAPACITY) + nal_count] = b;
		end else if (nal_dest == TGT_PPS && nal_count < PPS_CAPACITY) begin
			pps_store[(pps_bank ? 0 : PPS_CAPACITY) + nal_count] = b;
		end
	endtask

	// Flip the bank only for a complete NAL that fits
	task automatic commit_nal();
		if (nal_count == 0) return;
		if (nal_dest == TGT_SPS && nal_count <= SPS_CAPACITY) begin
			sps_bank = ~sps_bank;
			sps_len = nal_count;
			sets_committed++;
		end else if (nal_dest == TGT_PPS && nal_count <= PPS_CAPACITY) begin
			pps_bank = ~pps_bank;
			pps_len = nal_count;
			sets_committed++;
		end
	endtask

	// Advance the shadow state by one input beat and queue its result, if any
	task automatic take_beat(input logic req, input logic [7:0] b, input logic first,
			input logic last, input logic ready, input logic sel, input logic [7:0] idx);
		capture_result_t r;
		r = '0;
		if (req == REQ_READ) begin
			r.kind = RES_READ;
			r.sps_len = sps_len[8:0];
			r.pps_len = pps_len[8:0];
			if (sel == SEL_SPS) begin
				if (idx < sps_len && idx < SPS_CAPACITY)
					r.rdata = sps_store[(sps_bank ? SPS_CAPACITY : 0) + idx];
			end else begin
				if (idx < pps_len && idx < PPS_CAPACITY)
					r.rdata = pps_store[(pps_bank ? PPS_CAPACITY : 0) + idx];
			end
			expected_q.push_back(r);
			return;
		end

		if (first) begin
			// A first byte always restarts parsing and drops any open NAL
			payload_seen = 2'd1;
			nal_count = '0;
			nal_left = '0;
			nal_dest = TGT_NONE;
			if (!cap_en || ready) begin
				phase = PH_IGNORE;
			end else if (b[4:0] >= 5'd1 && b[4:0] <= NAL_SINGLE_MAX) begin
				phase = PH_SINGLE;
				nal_dest = dest_of(b);
				store_nal_byte(b);
				nal_count = 16'd1;
			end else if (b[4:0] == NAL_STAP_A) begin
				phase = PH_LEN_HI;
			end else begin
				phase = PH_IGNORE;
			end
		end else if (phase != PH_IDLE) begin
			if (payload_seen < 2'd2) payload_seen++;
			case (phase)
				PH_SINGLE: begin
					store_nal_byte(b);
					if (nal_count < CNT_MAX) nal_count++;
					if (last) commit_nal();
				end
				PH_LEN_HI: begin
					nal_left = {b, 8'h00};
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					nal_left = nal_left | {8'h00, b};
					if (nal_left == 0) begin
						phase = PH_IGNORE;
					end else begin
						nal_count = '0;
						nal_dest = TGT_NONE;
						phase = PH_BODY;
					end
				end
				PH_BODY: begin
					if (nal_count == 0) nal_dest = dest_of(b);
					store_nal_byte(b);
					nal_count++;
					nal_left--;
					if (nal_left == 0) begin
						commit_nal();
						nal_count = '0;
						nal_dest = TGT_NONE;
						phase = PH_LEN_HI;
					end
				end
				default: ;
			endcase
		end

		if (!last) return;
		r.kind = RES_REPORT;
		r.sps_len = sps_len[8:0];
		r.pps_len = pps_len[8:0];
		r.apply = cap_en && !ready && payload_seen >= 2'd2 && sps_len != 0 && pps_len != 0;
		expected_q.push_back(r);
		phase = PH_IDLE;
		payload_seen = '0;
		nal_left = '0;
		nal_count = '0;
		nal_dest = TGT_NONE;
	endtask

	// Compare one result beat with the oldest expectation
	task automatic check_result();
		capture_result_t want;
		capture_result_t got;
		got.kind = res_kind_t'(m_tuser);
		got.sps_len = m_tdata[8:0];
		got.pps_len = m_tdata[17:9];
		got.apply = m_tdata[18];
		got.rdata = m_tdata[26:19];
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected result: kind %0d sps %0d pps %0d apply %0b data %02h",
					$realtime, got.kind, got.sps_len, got.pps_len, got.apply, got.rdata);
			return;
		end
		want = expected_q.pop_front();
		if (got.kind == RES_READ) reads_seen++;
		else reports_seen++;
		if (got.kind != want.kind || got.sps_len != want.sps_len ||
				got.pps_len != want.pps_len || got.apply != want.apply ||
				got.rdata != want.rdata) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t result mismatch", $realtime);
				$display("  expected: kind %0d sps %0d pps %0d apply %0b data %02h",
					want.kind, want.sps_len, want.pps_len, want.apply, want.rdata);
				$display("  actual:   kind %0d sps %0d pps %0d apply %0b data %02h",
					got.kind, got.sps_len, got.pps_len, got.apply, got.rdata);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en = 1'b0;
			phase = PH_IDLE;
			nal_left = '0;
			nal_count = '0;
			nal_dest = TGT_NONE;
			payload_seen = '0;
			sps_bank = 1'b0;
			pps_bank = 1'b0;
			sps_len = '0;
			pps_len = '0;
			expected_q.delete();
			mismatches = 0;
			reports_seen = 0;
			reads_seen = 0;
			sets_committed = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Check outputs first so a result cannot match a beat taken at the same edge
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready)
				take_beat(s_tuser[0], s_tdata[7:0], s_tdata[8], s_tlast, s_tdata[9],
					s_tuser[1], s_tdata[17:10]);
			// Register write lands after the beat at this edge saw the old value
			if (psel && penable && pwrite && pready && paddr == CAPTURE_ENABLE_ADDR)
				cap_en = pwdata[0];
			fail_count <= mismatches;
			pending <= expected_q.size();
		end
	end

endmodule

@@ verif/h264_rtp_param_set_capture_top_tb.sv @@
// Testbench top: clock, reset, payload and read stimulus, register writes and verdict.
`timescale 1ns / 1ps

module h264_rtp_param_set_capture_top_tb;
	import hrpc_pkg::*;

	localparam logic [2:0] CAPTURE_ENABLE_ADDR = {REG_CAPTURE_ENABLE, 2'b00};
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [31:0] m_tdata;
	logic m_tuser;

	int fail_count;
	int pending;
	int reports_seen;
	int reads_seen;
	int sets_committed;

	logic [7:0] payload_q[$];
	logic idle_on = 1'b0;
	logic payload_open;
	int beats_sent;
	int enable_writes;
	int stall_left = 0;
	int idle_cycles = 0;

	h264_rtp_param_set_capture_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	h264_rtp_param_set_capture_checker i_capture_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.fail_count(fail_count),
		.pending(pending),
		.reports_seen(reports_seen),
		.reads_seen(reads_seen),
		.sets_committed(sets_committed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 12) begin
			stall_left <= $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one input beat, with an optional gap before it, and hold until taken
	task automatic send_beat(input logic req, input logic [7:0] b, input logic first,
			input logic last, input logic ready, input logic sel, input logic [7:0] idx);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 15) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, idx, ready, first, b};
		s_tuser <= {sel, req};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Read request; the payload-side fields carry noise
	task automatic send_read(input logic sel, input logic [7:0] idx);
		send_beat(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), sel, idx);
	endtask

	task automatic send_random_read();
		send_read(1'($urandom),
			($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
	endtask

	// Byte with no first flag; with last set it still yields a report
	task automatic send_stray(input logic last);
		send_beat(REQ_PAYLOAD, 8'($urandom), 1'b0, last, 1'($urandom), 1'($urandom),
			8'($urandom));
		if (last) payload_open = 1'b0;
	endtask

	// Send the buffered payload, now and then with a read slipped in between bytes
	task automatic send_payload(input logic ready, input logic drop_last);
		logic rdy;
		for (int i = 0; i < payload_q.size(); i++) begin
			if ($urandom_range(0, 99) < 8) send_random_read();
			rdy = (i != 0 && $urandom_range(0, 19) == 0) ? ~ready : ready;
			send_beat(REQ_PAYLOAD, payload_q[i], i == 0,
				i == payload_q.size() - 1 && !drop_last, rdy, 1'($urandom), 8'($urandom));
		end
		payload_open = drop_last;
	endtask

	function automatic void add_header(input logic [4:0] nal_type);
		payload_q.push_back({3'($urandom), nal_type});
	endfunction

	function automatic void add_body(input int n);
		repeat (n) payload_q.push_back(8'($urandom));
	endfunction

	// Single-NAL payload of n bytes, header included
	function automatic void build_single(input logic [4:0] nal_type, input int n);
		payload_q.delete();
		add_header(nal_type);
		add_body(n - 1);
	endfunction

	// One STAP-A entry: declared length, then n NAL bytes
	function automatic void add_stap_nal(input logic [4:0] nal_type, input int n,
			input int declared);
		logic [15:0] len16;
		len16 = 16'(declared);
		payload_q.push_back(len16[15:8]);
		payload_q.push_back(len16[7:0]);
		add_header(nal_type);
		add_body(n - 1);
	endfunction

	function automatic void start_stap();
		payload_q.delete();
		add_header(NAL_STAP_A);
	endfunction

	function automatic logic [4:0] pick_nal_type();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return NAL_SPS;
		if (r < 80) return NAL_PPS;
		return 5'($urandom_range(1, 23));
	endfunction

	// Mostly short NALs, a few right around the store capacity
	function automatic int pick_nal_len();
		if ($urandom_range(0, 99) < 3) return $urandom_range(SPS_CAPACITY - 2, SPS_CAPACITY + 2);
		return $urandom_range(1, 12);
	endfunction

	task automatic random_payload();
		int kind;
		int nals;
		int ending;
		int len;
		logic ready;
		logic drop_last;
		kind = $urandom_range(0, 99);
		ready = ($urandom_range(0, 9) == 0);
		drop_last = ($urandom_range(0, 19) == 0);
		if (kind < 40) begin
			build_single(pick_nal_type(), pick_nal_len());
		end else if (kind < 75) begin
			start_stap();
			nals = $urandom_range(1, 3);
			ending = $urandom_range(0, 9);
			for (int k = 0; k < nals; k++) begin
				len = pick_nal_len();
				// truncated walk: last entry promises more bytes than it has
				add_stap_nal(pick_nal_type(), len,
					(k == nals - 1 && ending == 1) ? len + $urandom_range(1, 5) : len);
			end
			if (ending == 0) begin
				// zero length ends the walk; trailing bytes are ignored
				payload_q.push_back(8'h00);
				payload_q.push_back(8'h00);
				add_body($urandom_range(0, 3));
			end else if (ending == 2) begin
				payload_q.push_back(8'($urandom));
			end
		end else if (kind < 85) begin
			payload_q.delete();
			add_header(($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(25, 31)));
			add_body($urandom_range(0, 6));
		end else if (kind < 92) begin
			payload_q.delete();
			add_header(5'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) send_stray(1'($urandom));
			return;
		end
		send_payload(ready, drop_last);
		if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) send_random_read();
	endtask

	task automatic random_phase(input int n, input int calm_from);
		int base;
		base = beats_sent;
		while (beats_sent - base < n) begin
			// alternate stretches with and without idling
			idle_on <= (beats_sent - base < calm_from) && (((beats_sent - base) / 150) % 3 != 2);
			random_payload();
		end
	endtask

	// Wait until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_capture_enable(input logic value);
		if (payload_open) send_stray(1'b1);
		drain();
		// payload bytes give no result, so let the pipeline empty as well
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPTURE_ENABLE_ADDR;
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		enable_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		beats_sent = 0;
		enable_writes = 0;
		payload_open = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stores, then a payload while capture is still off
		send_read(SEL_SPS, 8'd0);
		send_read(SEL_PPS, 8'd255);
		build_single(NAL_SPS, 3);
		send_payload(1'b0, 1'b0);
		set_capture_enable(1'b1);

		// Stray byte, one-byte payload, then one SPS and one PPS
		send_stray(1'b1);
		build_single(NAL_SPS, 1);
		send_payload(1'b0, 1'b0);
		build_single(NAL_SPS, 4);
		send_payload(1'b0, 1'b0);
		build_single(NAL_PPS, 3);
		send_payload(1'b0, 1'b0);
		// Source already set up: ignored
		build_single(NAL_PPS, 2);
		send_payload(1'b1, 1'b0);
		send_read(SEL_SPS, 8'd3);
		send_read(SEL_SPS, 8'd4);
		send_read(SEL_PPS, 8'd2);
		// STAP-A: both sets, then a zero length
		start_stap();
		add_stap_nal(NAL_SPS, 2, 2);
		add_stap_nal(NAL_PPS, 2, 2);
		payload_q.push_back(8'h00);
		payload_q.push_back(8'h00);
		send_payload(1'b0, 1'b0);
		// STAP-A: truncated NAL, then a lone trailing length byte
		start_stap();
		add_stap_nal(NAL_SPS, 3, 5);
		send_payload(1'b0, 1'b0);
		start_stap();
		add_stap_nal(NAL_PPS, 2, 2);
		payload_q.push_back(8'h01);
		send_payload(1'b0, 1'b0);
		// Reserved NAL types are ignored
		build_single(5'd0, 2);
		send_payload(1'b0, 1'b0);
		build_single(5'd31, 2);
		send_payload(1'b0, 1'b0);
		// New first byte abandons an open NAL
		build_single(NAL_SPS, 5);
		send_payload(1'b0, 1'b1);
		build_single(NAL_PPS, 2);
		send_payload(1'b0, 1'b0);

		// Full-capacity SPS and an oversize PPS
		build_single(NAL_SPS, SPS_CAPACITY);
		send_payload(1'b0, 1'b0);
		send_read(SEL_SPS, 8'd255);
		build_single(NAL_PPS, PPS_CAPACITY + 1);
		send_payload(1'b0, 1'b0);
		send_read(SEL_PPS, 8'd1);

		random_phase(380, 380);
		set_capture_enable(1'b0);
		random_phase(100, 100);
		set_capture_enable(1'b1);
		// no idling over the last part of the run
		random_phase(210, 120);
		idle_on <= 1'b0;
		if (payload_open) send_stray(1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d input beats and %0d enable writes", beats_sent, enable_writes);
		$display("checked %0d payload reports and %0d reads; %0d sets committed",
			reports_seen, reads_seen, sets_committed);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d result beats failed", fail_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hrpc_pkg.sv
sv/hrpc_front.sv
sv/hrpc_queue.sv
sv/hrpc_back.sv
sv/h264_rtp_param_set_capture_top.sv
verif/h264_rtp_param_set_capture_checker.sv
verif/h264_rtp_param_set_capture_top_tb.sv
